// ----- rtl/core/axl_pkg.sv -----
// Shared types, constants and helpers of the axis-angle rotation matrix block.
`timescale 1ns / 1ps
package axl_pkg;

	localparam int SQRT_STEPS   = 30;
	localparam int CORDIC_STEPS = 30;
	localparam int QUOT_BITS    = 18;

	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [33:0] K_Q30       = 34'sd652032874;
	localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
	localparam logic signed [15:0] ZERO_Q14    = 16'sd0;

	// One queued word: raw axis, reduced angle, its quadrant fold and the zero-axis flag.
	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [31:0] th;
		logic               neg;
		logic               zero;
	} axl_item_t;

	// Queue control between front and back.
	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} axl_qctl_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	// Round a Q.48 sum to Q.14 (half up, floor shift) and clamp to 16 bits.
	function automatic logic signed [15:0] round_sat(input logic signed [59:0] acc);
		logic signed [59:0] r;
		r = (acc + (60'sd1 <<< 33)) >>> 34;
		if (r > 60'sd32767)
			return 16'sd32767;
		if (r < -60'sd32768)
			return -16'sd32768;
		return r[15:0];
	endfunction

endpackage

// ----- rtl/core/axl_front.sv -----
// Front end: take a word, flag a zero axis and fold the angle into [-pi/2, pi/2].
`timescale 1ns / 1ps
module axl_front (
	input  logic                  start,
	input  logic                  full,
	input  logic signed [15:0]    axis_x,
	input  logic signed [15:0]    axis_y,
	input  logic signed [15:0]    axis_z,
	input  logic signed [15:0]    angle,
	output logic                  push,
	output axl_pkg::axl_item_t    item
);
	import axl_pkg::*;

	logic signed [35:0] th0;
	logic signed [35:0] th1;
	logic signed [35:0] th2;
	logic               neg;

	always_comb begin
		th0 = 36'(angle) <<< 18;
		if (th0 > PI_Q30)
			th1 = th0 - TWO_PI_Q30;
		else if (th0 < -PI_Q30)
			th1 = th0 + TWO_PI_Q30;
		else
			th1 = th0;
		// fold outer half-turns onto the CORDIC range and negate later
		if (th1 > HALF_PI_Q30) begin
			th2 = th1 - PI_Q30;
			neg = 1'b1;
		end else if (th1 < -HALF_PI_Q30) begin
			th2 = th1 + PI_Q30;
			neg = 1'b1;
		end else begin
			th2 = th1;
			neg = 1'b0;
		end
	end

	assign push      = start && !full;
	assign item.ax   = axis_x;
	assign item.ay   = axis_y;
	assign item.az   = axis_z;
	assign item.th   = th2[31:0];
	assign item.neg  = neg;
	assign item.zero = (axis_x == 16'sd0) && (axis_y == 16'sd0) && (axis_z == 16'sd0);

endmodule

// ----- rtl/core/axl_queue.sv -----
// Short queue between the front end and the compute pipeline.
`timescale 1ns / 1ps
module axl_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               pop,
	input  axl_pkg::axl_item_t wdata,
	output axl_pkg::axl_item_t rdata,
	output logic               full,
	output logic               empty
);
	import axl_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	axl_item_t       mem_q [0:DEPTH-1];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- rtl/core/axl_back.sv -----
// Back end: square root and CORDIC side by side, axis division, then the matrix products.
`timescale 1ns / 1ps
module axl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  axl_pkg::axl_item_t in_item,
	output logic               strobe,
	output logic signed [15:0] m00,
	output logic signed [15:0] m01,
	output logic signed [15:0] m02,
	output logic signed [15:0] m10,
	output logic signed [15:0] m11,
	output logic signed [15:0] m12,
	output logic signed [15:0] m20,
	output logic signed [15:0] m21,
	output logic signed [15:0] m22,
	output logic               axis_zero
);
	import axl_pkg::*;

	localparam int LATENCY = SQRT_STEPS + QUOT_BITS + 3;

	typedef struct packed {
		logic [59:0]        n;
		logic [59:0]        r;
		logic signed [33:0] cx;
		logic signed [33:0] cy;
		logic signed [33:0] z;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic               neg;
		logic               zero;
	} ph1_t;

	typedef struct packed {
		logic [2:0][46:0]   rem;
		logic [2:0][17:0]   q;
		logic [2:0]         sgn;
		logic [29:0]        len;
		logic signed [17:0] c;
		logic signed [17:0] s;
		logic               zero;
	} ph2_t;

	// stage 1: queued word and squared length
	axl_item_t          it_s1;
	logic [31:0]        len2_s1;
	logic               v_s1;

	always_ff @(posedge clk) begin
		it_s1   <= in_item;
		len2_s1 <= 32'(in_item.ax * in_item.ax) + 32'(in_item.ay * in_item.ay)
			+ 32'(in_item.az * in_item.az);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= in_valid;
	end

	// root and rotation stages run in lock step
	ph1_t                  p_s2 [0:SQRT_STEPS-1];
	logic [SQRT_STEPS-1:0] pv_s2;
	ph1_t                  p_init;

	always_comb begin
		p_init.n    = {len2_s1, 28'd0};
		p_init.r    = '0;
		p_init.cx   = K_Q30;
		p_init.cy   = '0;
		p_init.z    = 34'(it_s1.th);
		p_init.ax   = it_s1.ax;
		p_init.ay   = it_s1.ay;
		p_init.az   = it_s1.az;
		p_init.neg  = it_s1.neg;
		p_init.zero = it_s1.zero;
	end

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_ph1
		localparam logic [59:0] BITV = 60'd1 << (58 - 2 * i);
		ph1_t prv;
		ph1_t nxt;
		logic pv;
		if (i == 0) begin : g_first
			assign prv = p_init;
			assign pv  = v_s1;
		end else begin : g_rest
			assign prv = p_s2[i-1];
			assign pv  = pv_s2[i-1];
		end
		always_comb begin
			logic [59:0]        tsum;
			logic signed [33:0] dx;
			logic signed [33:0] dy;
			logic signed [33:0] at;
			nxt  = prv;
			tsum = prv.r + BITV;
			if (prv.n >= tsum) begin
				nxt.n = prv.n - tsum;
				nxt.r = (prv.r >> 1) + BITV;
			end else begin
				nxt.r = prv.r >> 1;
			end
			dx = prv.cy >>> i;
			dy = prv.cx >>> i;
			at = 34'(atan_q30(5'(i)));
			if (prv.z >= 34'sd0) begin
				nxt.cx = prv.cx - dx;
				nxt.cy = prv.cy + dy;
				nxt.z  = prv.z - at;
			end else begin
				nxt.cx = prv.cx + dx;
				nxt.cy = prv.cy - dy;
				nxt.z  = prv.z + at;
			end
		end
		always_ff @(posedge clk) begin
			p_s2[i] <= nxt;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				pv_s2[i] <= 1'b0;
			else
				pv_s2[i] <= pv;
		end
	end

	// restoring division of each axis magnitude by the length
	ph2_t                 d_s3 [0:QUOT_BITS-1];
	logic [QUOT_BITS-1:0] dv_s3;
	ph2_t                 d_init;

	always_comb begin
		ph1_t               e;
		logic signed [15:0] comp [0:2];
		logic [15:0]        mag;
		logic signed [33:0] cxn;
		logic signed [33:0] cyn;
		e       = p_s2[SQRT_STEPS-1];
		comp[0] = e.ax;
		comp[1] = e.ay;
		comp[2] = e.az;
		d_init.len  = e.r[29:0];
		d_init.zero = e.zero;
		for (int k = 0; k < 3; k++) begin
			mag = comp[k][15] ? 16'(-17'(comp[k])) : comp[k];
			d_init.sgn[k] = comp[k][15];
			d_init.q[k]   = '0;
			d_init.rem[k] = (47'(mag) << 30) + 47'(e.r[29:1]);
		end
		cxn = e.neg ? -e.cx : e.cx;
		cyn = e.neg ? -e.cy : e.cy;
		d_init.c = 18'((cxn + 34'sd8192) >>> 14);
		d_init.s = 18'((cyn + 34'sd8192) >>> 14);
	end

	for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
		ph2_t prv;
		ph2_t nxt;
		logic pv;
		if (j == 0) begin : g_first
			assign prv = d_init;
			assign pv  = pv_s2[SQRT_STEPS-1];
		end else begin : g_rest
			assign prv = d_s3[j-1];
			assign pv  = dv_s3[j-1];
		end
		always_comb begin
			logic [46:0] dvs;
			nxt = prv;
			dvs = 47'(prv.len) << (QUOT_BITS - 1 - j);
			for (int k = 0; k < 3; k++) begin
				if (prv.rem[k] >= dvs) begin
					nxt.rem[k] = prv.rem[k] - dvs;
					nxt.q[k][QUOT_BITS-1-j] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			d_s3[j] <= nxt;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_s3[j] <= 1'b0;
			else
				dv_s3[j] <= pv;
		end
	end

	// stage 4: axis products and axis times sine
	logic signed [37:0] p00_s4, p01_s4, p02_s4, p11_s4, p12_s4, p22_s4;
	logic signed [36:0] t0_s4, t1_s4, t2_s4;
	logic signed [19:0] omc_s4;
	logic signed [17:0] c_s4;
	logic               zero_s4;
	logic               v_s4;

	always_ff @(posedge clk) begin
		ph2_t               e;
		logic signed [18:0] u [0:2];
		e = d_s3[QUOT_BITS-1];
		for (int k = 0; k < 3; k++)
			u[k] = e.sgn[k] ? -19'(e.q[k]) : 19'(e.q[k]);
		p00_s4  <= u[0] * u[0];
		p01_s4  <= u[0] * u[1];
		p02_s4  <= u[0] * u[2];
		p11_s4  <= u[1] * u[1];
		p12_s4  <= u[1] * u[2];
		p22_s4  <= u[2] * u[2];
		t0_s4   <= u[0] * e.s;
		t1_s4   <= u[1] * e.s;
		t2_s4   <= u[2] * e.s;
		omc_s4  <= 20'sd65536 - 20'(e.c);
		c_s4    <= e.c;
		zero_s4 <= e.zero;
	end

	// stage 5: scale by one minus cosine
	logic signed [57:0] a00_s5, a01_s5, a02_s5, a11_s5, a12_s5, a22_s5;
	logic signed [59:0] t0_s5, t1_s5, t2_s5;
	logic signed [59:0] cd_s5;
	logic               zero_s5;
	logic               v_s5;

	always_ff @(posedge clk) begin
		a00_s5  <= p00_s4 * omc_s4;
		a01_s5  <= p01_s4 * omc_s4;
		a02_s5  <= p02_s4 * omc_s4;
		a11_s5  <= p11_s4 * omc_s4;
		a12_s5  <= p12_s4 * omc_s4;
		a22_s5  <= p22_s4 * omc_s4;
		t0_s5   <= 60'(t0_s4) <<< 16;
		t1_s5   <= 60'(t1_s4) <<< 16;
		t2_s5   <= 60'(t2_s4) <<< 16;
		cd_s5   <= 60'(c_s4) <<< 32;
		zero_s5 <= zero_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= dv_s3[QUOT_BITS-1];
			v_s5 <= v_s4;
		end
	end

	// output register: sum, round, clamp; identity for a zero axis
	logic signed [15:0] m_q [0:8];
	logic               zero_q;
	logic               strobe_q;

	always_ff @(posedge clk) begin
		if (zero_s5) begin
			for (int k = 0; k < 9; k++)
				m_q[k] <= (k % 4 == 0) ? ONE_Q14 : ZERO_Q14;
		end else begin
			m_q[0] <= round_sat(60'(a00_s5) + cd_s5);
			m_q[1] <= round_sat(60'(a01_s5) + t2_s5);
			m_q[2] <= round_sat(60'(a02_s5) - t1_s5);
			m_q[3] <= round_sat(60'(a01_s5) - t2_s5);
			m_q[4] <= round_sat(60'(a11_s5) + cd_s5);
			m_q[5] <= round_sat(60'(a12_s5) + t0_s5);
			m_q[6] <= round_sat(60'(a02_s5) + t1_s5);
			m_q[7] <= round_sat(60'(a12_s5) - t0_s5);
			m_q[8] <= round_sat(60'(a22_s5) + cd_s5);
		end
		zero_q <= zero_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= v_s5;
	end

	assign strobe    = strobe_q;
	assign m00       = m_q[0];
	assign m01       = m_q[1];
	assign m02       = m_q[2];
	assign m10       = m_q[3];
	assign m11       = m_q[4];
	assign m12       = m_q[5];
	assign m20       = m_q[6];
	assign m21       = m_q[7];
	assign m22       = m_q[8];
	assign axis_zero = zero_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ##LATENCY strobe_q)
		else $error("word lost in pipeline");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && zero_q) |-> (m_q[0] == ONE_Q14 && m_q[4] == ONE_Q14
			&& m_q[8] == ONE_Q14 && m_q[1] == ZERO_Q14 && m_q[5] == ZERO_Q14))
		else $error("zero axis did not give identity");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |=> (zero_q == $past(zero_s5)))
		else $error("zero flag mismatch");

endmodule

// ----- rtl/core/axis_angle_rotation_matrix.sv -----
// Top level of the axis-angle to 3x3 rotation matrix engine.
// Takes one word per clock: a word is accepted when start is high and busy is low, and
// its nine matrix entries plus the zero-axis flag appear for exactly one cycle with
// strobe high, in acceptance order, once the word has passed the queue, the squared-
// length stage, the 30-stage square root and CORDIC pipeline, the 18-stage axis divider
// and three product stages. The queue behind the front end only fills if the pipeline
// is blocked, which it never is, so busy stays low in use. The receiver cannot stall.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic signed [15:0] angle,
	output logic               strobe,
	output logic signed [15:0] m00,
	output logic signed [15:0] m01,
	output logic signed [15:0] m02,
	output logic signed [15:0] m10,
	output logic signed [15:0] m11,
	output logic signed [15:0] m12,
	output logic signed [15:0] m20,
	output logic signed [15:0] m21,
	output logic signed [15:0] m22,
	output logic               axis_zero
);
	import axl_pkg::*;

	axl_qctl_t qctl;
	axl_item_t wr_item;
	axl_item_t rd_item;

	axl_front u_front (
		.start  (start),
		.full   (qctl.full),
		.axis_x (axis_x),
		.axis_y (axis_y),
		.axis_z (axis_z),
		.angle  (angle),
		.push   (qctl.push),
		.item   (wr_item)
	);

	axl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (qctl.push),
		.pop    (qctl.pop),
		.wdata  (wr_item),
		.rdata  (rd_item),
		.full   (qctl.full),
		.empty  (qctl.empty)
	);

	// the pipeline never stalls: drain a word every cycle while the queue is not empty
	assign qctl.pop = !qctl.empty;
	assign busy     = qctl.full;

	axl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (qctl.pop),
		.in_item   (rd_item),
		.strobe    (strobe),
		.m00       (m00),
		.m01       (m01),
		.m02       (m02),
		.m10       (m10),
		.m11       (m11),
		.m12       (m12),
		.m20       (m20),
		.m21       (m21),
		.m22       (m22),
		.axis_zero (axis_zero)
	);

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the axis-angle rotation matrix block.
`timescale 1ns / 1ps
module tb;
	import axl_pkg::*;

	typedef struct packed {
		logic [8:0][15:0] m;
		logic             zero;
	} matrix_t;

	typedef struct {
		logic signed [15:0] ax, ay, az, ang;
		bit                 typed;
		matrix_t            want;
	} vec_row_t;

	localparam matrix_t IDENT = '{m: {16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384,
		16'sd0, 16'sd0, 16'sd0, 16'sd16384}, zero: 1'b1};

	localparam longint ARCTAN [30] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
		64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0, angle = '0;
	logic busy, strobe, axis_zero;
	logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

	int errors = 0;
	int idle_pct = 0;
	matrix_t pending_words [$];
	// typed-in expectation travelling with the word on the input ports
	bit row_typed = 1'b0;
	matrix_t row_want;

	always #6 clk = ~clk;

	axis_angle_rotation_matrix u_dut (.*);

	task automatic report(input string what);
		$display("tb: mismatch: %s", what);
		errors++;
	endtask

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unit_comp(input longint v, input longint len);
		longint mag = v < 0 ? -v : v;
		longint q = (mag * (64'sd1 << 30) + len / 2) / len;
		return v < 0 ? -q : q;
	endfunction

	function automatic logic [15:0] to_q14(input longint acc);
		longint r = (acc + (64'sd1 << 33)) >>> 34;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

	// Rodrigues matrix for one axis-angle word, row-major.
	function automatic matrix_t rotation(input logic signed [15:0] ax, ay, az, ang);
		matrix_t res;
		longint v [3];
		longint u [3];
		longint th, len, cx, cy, dx, dy, c, s, omc, acc, t;
		longint unsigned len2;
		bit neg = 0;
		int k;
		v[0] = ax;
		v[1] = ay;
		v[2] = az;
		len2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
		if (len2 == 0)
			return IDENT;
		len = int_sqrt(len2 << 28);
		for (int i = 0; i < 3; i++)
			u[i] = unit_comp(v[i], len);
		th = longint'(ang) * 262144;
		if (th > longint'(PI_Q30))
			th -= longint'(TWO_PI_Q30);
		else if (th < -longint'(PI_Q30))
			th += longint'(TWO_PI_Q30);
		if (th > longint'(HALF_PI_Q30)) begin
			th -= longint'(PI_Q30);
			neg = 1;
		end else if (th < -longint'(HALF_PI_Q30)) begin
			th += longint'(PI_Q30);
			neg = 1;
		end
		cx = longint'(K_Q30);
		cy = 0;
		for (int i = 0; i < 30; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (th >= 0) begin
				cx -= dx;
				cy += dy;
				th -= ARCTAN[i];
			end else begin
				cx += dx;
				cy -= dy;
				th += ARCTAN[i];
			end
		end
		if (neg) begin
			cx = -cx;
			cy = -cy;
		end
		c = (cx + (64'sd1 << 13)) >>> 14;
		s = (cy + (64'sd1 << 13)) >>> 14;
		omc = 65536 - c;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = u[i] * u[j] * omc;
				if (i == j) begin
					acc += c * (64'sd1 << 32);
				end else begin
					k = 3 - i - j;
					t = u[k] * s * 65536;
					if ((j - i + 3) % 3 == 1)
						acc += t;
					else
						acc -= t;
				end
				res.m[8 - (3 * i + j)] = to_q14(acc);
			end
		res.zero = 1'b0;
		return res;
	endfunction

	// Record every accepted word and check every strobed matrix.
	always @(posedge clk) begin
		matrix_t got, want;
		if (arst_n && start && !busy)
			pending_words.push_back(row_typed ? row_want
				: rotation(axis_x, axis_y, axis_z, angle));
		if (arst_n && strobe) begin
			got.m = {m00, m01, m02, m10, m11, m12, m20, m21, m22};
			got.zero = axis_zero;
			if (pending_words.size() == 0) begin
				report("matrix with nothing outstanding");
			end else begin
				want = pending_words.pop_front();
				for (int f = 0; f < 9; f++)
					if (got.m[8 - f] !== want.m[8 - f])
						report($sformatf("m%0d%0d got %0d want %0d", f / 3, f % 3,
							$signed(got.m[8 - f]), $signed(want.m[8 - f])));
				if (got.zero !== want.zero)
					report($sformatf("axis_zero got %b want %b", got.zero, want.zero));
			end
		end
	end

	task automatic send(input logic signed [15:0] ax, ay, az, ang);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		axis_x <= ax;
		axis_y <= ay;
		axis_z <= az;
		angle <= ang;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_comp(input int mode);
		case (mode)
			0: return 16'sd0;
			1: return 16'($signed($urandom_range(8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	vec_row_t vectors [$];

	task automatic add_row(input logic signed [15:0] ax, ay, az, ang);
		vec_row_t r;
		r.ax = ax;
		r.ay = ay;
		r.az = az;
		r.ang = ang;
		r.typed = (ax == 0 && ay == 0 && az == 0);
		r.want = IDENT;
		vectors.push_back(r);
	endtask

	initial begin
		int mode;
		// zero axis rows carry the identity typed in
		add_row(0, 0, 0, 0);
		add_row(0, 0, 0, -32768);
		add_row(0, 0, 0, 32767);
		add_row(0, 0, 0, 6434);
		add_row(32767, 32767, 32767, 32767);
		add_row(-32768, -32768, -32768, -32768);
		add_row(32767, -32768, 0, 12868);
		add_row(4096, 0, 0, 6434);
		add_row(0, 4096, 0, -6434);
		add_row(0, 0, 4096, 12868);
		add_row(0, 0, -4096, 12869);
		add_row(1, 0, 0, -12868);
		add_row(0, -1, 0, -12869);
		add_row(0, 0, 1, 6433);
		add_row(-1, -1, -1, -6433);
		add_row(4096, 4096, 0, 25736);
		add_row(-32768, 1, 1, -25737);
		add_row(100, -200, 300, 0);
		add_row(-32768, 0, 0, 32767);
		add_row(0, 32767, 0, -32768);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vectors[i]) begin
			row_typed <= vectors[i].typed;
			row_want <= vectors[i].want;
			send(vectors[i].ax, vectors[i].ay, vectors[i].az, vectors[i].ang);
		end
		row_typed <= 1'b0;

		for (int n = 0; n < 850; n++) begin
			case (n / 170)
				0, 3: idle_pct = 0;
				1: idle_pct = 85;
				2: idle_pct = 26;
				default: idle_pct = n % 2 ? 85 : 0;
			endcase
			mode = $urandom_range(9);
			if (mode == 0)
				send(0, 0, 0, 16'($urandom));
			else if (mode == 1)
				send(rand_comp($urandom_range(1)), rand_comp($urandom_range(1)),
					rand_comp(1), 16'($urandom));
			else
				send(rand_comp(2), rand_comp(2), rand_comp(2), 16'($urandom));
		end
		start <= 1'b0;

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: done, errors");
		$finish;
	end

endmodule
